// File: design/wavetable_three_voice_synth_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wavetable synth
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_THREE_VOICE_SYNTH_UNIT_ASSERT_SVH
`define WAVETABLE_THREE_VOICE_SYNTH_UNIT_ASSERT_SVH

// same-cycle implication
`define WTSYN_AST_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WTSYN_AST_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/wtsyn_pkg.sv
// ----------------------------------------------------------------------------
// wtsyn_pkg
// Shared widths, codes and types of the wavetable synth.
// ----------------------------------------------------------------------------
package wtsyn_pkg;

	// transaction fields
	localparam int CMD_W      = 2;
	localparam int REG_IDX_W  = 5;
	localparam int NIB_W      = 4;
	localparam int WAVE_IDX_W = 8;
	localparam int MIX_W      = 16;
	localparam int OUT_W      = 16;

	// commands
	localparam logic [CMD_W-1:0] CMD_REG_WR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WAVE_WR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;

	// sound register file
	localparam int NUM_REGS = 32;
	localparam int FREQ_W   = 20;
	localparam int WSEL_W   = 3;
	localparam int POS_W    = 5;
	localparam int WAVE_DEPTH = 256;

	localparam logic [REG_IDX_W-1:0] REG_FREQ0 = 5'h10; // voice 0 bits 3:0
	localparam logic [REG_IDX_W-1:0] REG_FREQ1 = 5'h16; // voice 1 bits 7:4
	localparam logic [REG_IDX_W-1:0] REG_FREQ2 = 5'h1b; // voice 2 bits 7:4
	localparam logic [REG_IDX_W-1:0] REG_VOL0  = 5'h15;
	localparam logic [REG_IDX_W-1:0] REG_VOL1  = 5'h1a;
	localparam logic [REG_IDX_W-1:0] REG_VOL2  = 5'h1f;
	localparam logic [REG_IDX_W-1:0] REG_WSEL0 = 5'h05;
	localparam logic [REG_IDX_W-1:0] REG_WSEL1 = 5'h0a;
	localparam logic [REG_IDX_W-1:0] REG_WSEL2 = 5'h0f;

	// voices
	localparam int VOICES  = 3;
	localparam int VOICE_W = 2;
	localparam int PHASE_W = 32;

	// configuration
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SCALE_W    = 16;
	localparam logic       CFG_PHASE_SCALE = 1'b0; // word index of phase_scale
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd8192;

	// arithmetic
	localparam int MUL_A_W = 21;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int SMP_W   = 5;   // sample minus offset, signed
	localparam int SUM_W   = 10;  // three voices of -120..105
	localparam int SAT_W   = 18;
	localparam logic signed [SMP_W-1:0] SMP_OFFSET = 5'sd8;
	localparam logic signed [MUL_B_W-1:0] MIX_GAIN = 17'sd40;
	localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

	// multiplier operations
	localparam logic [1:0] MUL_STEP  = 2'd0; // frequency * phase_scale
	localparam logic [1:0] MUL_VOICE = 2'd1; // volume * (sample - 8)
	localparam logic [1:0] MUL_GAIN  = 2'd2; // voice sum * 40

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [NIB_W-1:0]  vol;
		logic [WSEL_W-1:0] wsel;
		logic              active;
	} voice_cfg_t;

	typedef struct packed {
		logic [1:0]               op;
		logic [FREQ_W-1:0]        freq;
		logic [SCALE_W-1:0]       scale;
		logic [NIB_W-1:0]         vol;
		logic signed [SMP_W-1:0]  smp;
		logic signed [SUM_W-1:0]  sum;
	} mul_req_t;

endpackage

// File: design/wtsyn_if.sv
// ----------------------------------------------------------------------------
// wtsyn_if
// Valid/ready channels of the wavetable synth: command items and results.
// ----------------------------------------------------------------------------
interface wtsyn_item_if;
	logic                                  valid;
	logic                                  ready;
	logic [wtsyn_pkg::CMD_W-1:0]           command;
	logic [wtsyn_pkg::REG_IDX_W-1:0]       reg_index;
	logic [wtsyn_pkg::NIB_W-1:0]           reg_value;
	logic [wtsyn_pkg::WAVE_IDX_W-1:0]      wave_index;
	logic [wtsyn_pkg::NIB_W-1:0]           wave_value;
	logic signed [wtsyn_pkg::MIX_W-1:0]    mix_in;

	modport source (output valid, command, reg_index, reg_value, wave_index,
		wave_value, mix_in, input ready);
	modport sink (input valid, command, reg_index, reg_value, wave_index,
		wave_value, mix_in, output ready);
endinterface

interface wtsyn_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [wtsyn_pkg::OUT_W-1:0]    sample_out;

	modport source (output valid, sample_out, input ready);
	modport sink (input valid, sample_out, output ready);
endinterface

// File: design/wtsyn_ram.sv
// ----------------------------------------------------------------------------
// wtsyn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wtsyn_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/wtsyn_regs.sv
// ----------------------------------------------------------------------------
// wtsyn_regs
// 32 x 4-bit sound registers; decodes the fields of the selected voice.
// ----------------------------------------------------------------------------
module wtsyn_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             we,
	input  logic [wtsyn_pkg::REG_IDX_W-1:0]  idx,
	input  logic [wtsyn_pkg::NIB_W-1:0]      wdata,
	input  logic [wtsyn_pkg::VOICE_W-1:0]    voice,
	output wtsyn_pkg::voice_cfg_t            cfg
);

	logic [wtsyn_pkg::NIB_W-1:0] regs_q [wtsyn_pkg::NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wtsyn_pkg::NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (we) begin
			regs_q[idx] <= wdata;
		end
	end

	// voice 0 has a 20-bit frequency, voices 1 and 2 have bits 3:0 tied low
	always_comb begin
		cfg = '0;
		unique case (voice)
			2'd0: begin
				cfg.freq = {regs_q[wtsyn_pkg::REG_FREQ0 + 5'd4],
					regs_q[wtsyn_pkg::REG_FREQ0 + 5'd3],
					regs_q[wtsyn_pkg::REG_FREQ0 + 5'd2],
					regs_q[wtsyn_pkg::REG_FREQ0 + 5'd1],
					regs_q[wtsyn_pkg::REG_FREQ0]};
				cfg.vol  = regs_q[wtsyn_pkg::REG_VOL0];
				cfg.wsel = regs_q[wtsyn_pkg::REG_WSEL0][wtsyn_pkg::WSEL_W-1:0];
			end
			2'd1: begin
				cfg.freq = {regs_q[wtsyn_pkg::REG_FREQ1 + 5'd3],
					regs_q[wtsyn_pkg::REG_FREQ1 + 5'd2],
					regs_q[wtsyn_pkg::REG_FREQ1 + 5'd1],
					regs_q[wtsyn_pkg::REG_FREQ1], 4'h0};
				cfg.vol  = regs_q[wtsyn_pkg::REG_VOL1];
				cfg.wsel = regs_q[wtsyn_pkg::REG_WSEL1][wtsyn_pkg::WSEL_W-1:0];
			end
			2'd2: begin
				cfg.freq = {regs_q[wtsyn_pkg::REG_FREQ2 + 5'd3],
					regs_q[wtsyn_pkg::REG_FREQ2 + 5'd2],
					regs_q[wtsyn_pkg::REG_FREQ2 + 5'd1],
					regs_q[wtsyn_pkg::REG_FREQ2], 4'h0};
				cfg.vol  = regs_q[wtsyn_pkg::REG_VOL2];
				cfg.wsel = regs_q[wtsyn_pkg::REG_WSEL2][wtsyn_pkg::WSEL_W-1:0];
			end
			default: cfg = '0;
		endcase
		cfg.active = (cfg.vol != '0) && (cfg.freq != '0);
	end

endmodule

// File: design/wtsyn_mul.sv
// ----------------------------------------------------------------------------
// wtsyn_mul
// Shared signed 21x17 multiplier with operand select and registered product.
// ----------------------------------------------------------------------------
module wtsyn_mul (
	input  logic                                 clk,
	input  wtsyn_pkg::mul_req_t                  req,
	output logic signed [wtsyn_pkg::PROD_W-1:0]  prod
);

	logic signed [wtsyn_pkg::MUL_A_W-1:0] a;
	logic signed [wtsyn_pkg::MUL_B_W-1:0] b;
	logic signed [wtsyn_pkg::PROD_W-1:0]  prod_q;

	always_comb begin
		unique case (req.op)
			wtsyn_pkg::MUL_STEP: begin
				a = $signed({1'b0, req.freq});
				b = $signed({1'b0, req.scale});
			end
			wtsyn_pkg::MUL_VOICE: begin
				a = $signed({{(wtsyn_pkg::MUL_A_W - wtsyn_pkg::NIB_W){1'b0}}, req.vol});
				b = wtsyn_pkg::MUL_B_W'(req.smp);
			end
			wtsyn_pkg::MUL_GAIN: begin
				a = wtsyn_pkg::MUL_A_W'(req.sum);
				b = wtsyn_pkg::MIX_GAIN;
			end
			default: begin
				a = '0;
				b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= wtsyn_pkg::PROD_W'(a) * wtsyn_pkg::PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

// File: design/wavetable_three_voice_synth_unit.sv
// ----------------------------------------------------------------------------
// wavetable_three_voice_synth_unit: three-voice wavetable sound generator
// Register and wave-table writes are taken in idle and leave the input ready.
// A sample tick makes three passes per voice (READ, STEP, ACC), then GAIN and
// SAT, through the one shared multiplier.
// Reset clears sound registers and phases, sets phase_scale to 8192.
// ----------------------------------------------------------------------------
module wavetable_three_voice_synth_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	wtsyn_item_if.sink                          item,
	wtsyn_result_if.source                      result,
	// APB-style configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wtsyn_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [wtsyn_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [wtsyn_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                pready
);

	// Sequencer states. A tick walks READ -> STEP -> ACC once per voice,
	// then GAIN -> SAT. The multiplier result of each state's request is
	// seen in the state after it.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1; // wave RAM read, mul freq*scale
	localparam logic [2:0] ST_STEP = 3'd2; // phase update, mul vol*(smp-8)
	localparam logic [2:0] ST_ACC  = 3'd3; // accumulate voice product
	localparam logic [2:0] ST_GAIN = 3'd4; // mul sum*40
	localparam logic [2:0] ST_SAT  = 3'd5; // add mix_in, saturate, load output

	logic [2:0]                              state_q;
	logic [wtsyn_pkg::VOICE_W-1:0]           voice_q;
	logic signed [wtsyn_pkg::SUM_W-1:0]      sum_q;
	logic signed [wtsyn_pkg::MIX_W-1:0]      mix_q;
	logic [wtsyn_pkg::PHASE_W-1:0]           phase_q [wtsyn_pkg::VOICES];
	logic [wtsyn_pkg::SCALE_W-1:0]           scale_q;
	logic                                    out_valid_q;
	logic signed [wtsyn_pkg::OUT_W-1:0]      out_data_q;

	logic                                    item_acc;
	logic                                    cfg_wr;
	logic                                    out_free;
	wtsyn_pkg::voice_cfg_t                   vcfg;
	wtsyn_pkg::mul_req_t                     mreq;
	logic signed [wtsyn_pkg::PROD_W-1:0]     prod;
	logic [wtsyn_pkg::NIB_W-1:0]             ram_rdata;
	logic [wtsyn_pkg::WAVE_IDX_W-1:0]        ram_raddr;
	logic [wtsyn_pkg::PHASE_W-1:0]           phase_cur;
	logic signed [wtsyn_pkg::SAT_W-1:0]      mix_sum;
	logic signed [wtsyn_pkg::OUT_W-1:0]      sat_val;

	// ------------------------------------------------------------------
	// Handshakes
	// ------------------------------------------------------------------
	// Input is taken only between ticks; a finished result may still be
	// waiting in the output register while writes and the next tick go on.
	assign item.ready = (state_q == ST_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	assign result.valid      = out_valid_q;
	assign result.sample_out = out_data_q;

	// ------------------------------------------------------------------
	// Configuration: one register, phase_scale, at byte address 0
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[2] == wtsyn_pkg::CFG_PHASE_SCALE);
	assign prdata = (paddr[2] == wtsyn_pkg::CFG_PHASE_SCALE) ?
		wtsyn_pkg::CFG_DATA_W'(scale_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= wtsyn_pkg::SCALE_RESET;
		end else if (cfg_wr) begin
			scale_q <= pwdata[wtsyn_pkg::SCALE_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Storage: sound registers (flops, reset) and wave table (RAM, no reset)
	// ------------------------------------------------------------------
	wtsyn_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (item_acc && (item.command == wtsyn_pkg::CMD_REG_WR)),
		.idx    (item.reg_index),
		.wdata  (item.reg_value),
		.voice  (voice_q),
		.cfg    (vcfg)
	);

	// Table address: wave select, then top five phase bits of the voice.
	assign phase_cur = phase_q[voice_q];
	assign ram_raddr = {vcfg.wsel,
		phase_cur[wtsyn_pkg::PHASE_W-1 -: wtsyn_pkg::POS_W]};

	wtsyn_ram #(
		.WIDTH (wtsyn_pkg::NIB_W),
		.DEPTH (wtsyn_pkg::WAVE_DEPTH)
	) u_wave_ram (
		.clk   (clk),
		.we    (item_acc && (item.command == wtsyn_pkg::CMD_WAVE_WR)),
		.waddr (item.wave_index),
		.wdata (item.wave_value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Shared multiplier: operand set chosen by the state
	// ------------------------------------------------------------------
	always_comb begin
		mreq.freq  = vcfg.freq;
		mreq.scale = scale_q;
		mreq.vol   = vcfg.vol;
		// RAM data is valid in STEP, the cycle after the READ address
		mreq.smp   = $signed({1'b0, ram_rdata}) - wtsyn_pkg::SMP_OFFSET;
		mreq.sum   = sum_q;
		unique case (state_q) inside
			ST_STEP:         mreq.op = wtsyn_pkg::MUL_VOICE;
			// SAT repeats the gain request so the product holds while the
			// output register is full
			ST_GAIN, ST_SAT: mreq.op = wtsyn_pkg::MUL_GAIN;
			default:         mreq.op = wtsyn_pkg::MUL_STEP;
		endcase
	end

	wtsyn_mul u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod)
	);

	// ------------------------------------------------------------------
	// Final mix: mix_in + 40*sum, clamped to signed 16 bits
	// ------------------------------------------------------------------
	assign mix_sum = wtsyn_pkg::SAT_W'(mix_q) +
		$signed(prod[wtsyn_pkg::SAT_W-1:0]);

	always_comb begin
		if (mix_sum > wtsyn_pkg::SAT_W'(wtsyn_pkg::OUT_MAX)) begin
			sat_val = wtsyn_pkg::OUT_MAX;
		end else if (mix_sum < wtsyn_pkg::SAT_W'(wtsyn_pkg::OUT_MIN)) begin
			sat_val = wtsyn_pkg::OUT_MIN;
		end else begin
			sat_val = mix_sum[wtsyn_pkg::OUT_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Sequencer and voice state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			voice_q <= '0;
			sum_q   <= '0;
			for (int i = 0; i < wtsyn_pkg::VOICES; i++) begin
				phase_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc && (item.command == wtsyn_pkg::CMD_TICK)) begin
						voice_q <= '0;
						sum_q   <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_STEP;
				ST_STEP: begin
					// product holds freq*scale; wrap at 32 bits
					if (vcfg.active) begin
						phase_q[voice_q] <= phase_cur + prod[wtsyn_pkg::PHASE_W-1:0];
					end
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (vcfg.active) begin
						sum_q <= sum_q + $signed(prod[wtsyn_pkg::SUM_W-1:0]);
					end
					if (voice_q == wtsyn_pkg::VOICE_W'(wtsyn_pkg::VOICES - 1)) begin
						state_q <= ST_GAIN;
					end else begin
						voice_q <= voice_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_GAIN: state_q <= ST_SAT;
				ST_SAT: begin
					// hold here until the output register can take the sample
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// mix_in is captured with the tick transaction
	always_ff @(posedge clk) begin
		if (item_acc && (item.command == wtsyn_pkg::CMD_TICK)) begin
			mix_q <= item.mix_in;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_SAT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_SAT) && out_free) begin
			out_data_q <= sat_val;
		end
	end

endmodule

// File: design/wtsyn_chk.sv
// ----------------------------------------------------------------------------
// wtsyn_chk
// Port-level checks of the wavetable synth, bound to the top level.
// ----------------------------------------------------------------------------
`include "wavetable_three_voice_synth_unit_assert.svh"

module wtsyn_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               item_valid,
	input logic                               item_ready,
	input logic [wtsyn_pkg::CMD_W-1:0]        item_command,
	input logic                               result_valid,
	input logic                               result_ready,
	input logic signed [wtsyn_pkg::OUT_W-1:0] result_sample_out
);

	logic item_acc;
	assign item_acc = item_valid && item_ready;

	// no transaction yields a result in the very next cycle
	`WTSYN_AST_NXT(a_no_early_result, item_acc && !result_valid, !result_valid, "result too early")

	// a tick keeps the input closed while the voices are processed
	`WTSYN_AST_NXT(a_tick_busy, item_acc && (item_command == wtsyn_pkg::CMD_TICK), !item_ready, "ready during tick")

	// a new result is only loaded at the end of a tick, never from idle
	`WTSYN_AST_IMP(a_result_from_tick, $rose(result_valid), $past(!item_ready), "result without tick")

	// a stalled result holds
	`WTSYN_AST_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_sample_out), "result dropped")

endmodule

bind wavetable_three_voice_synth_unit wtsyn_chk u_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.item_command      (item.command),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.result_sample_out (result.sample_out)
);
